>>> sv/assert_macros.svh
// Assertion macros shared by the sorted key table RTL.
// Each macro expects signals clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define SKT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define SKT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SKT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/skt_pkg.sv
// Sizes, status codes and shared types of the sorted key table.
// No dependencies; used by every module of the block.
package skt_pkg;

	localparam int TABLE_DEPTH  = 256;
	localparam int MODE_COUNT   = 8;
	localparam int QUANTUM_BITS = 4;

	localparam int KEY_BITS = MODE_COUNT * QUANTUM_BITS;
	localparam int KEY_W    = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int PAY_W    = 64;
	localparam int IDX_W    = $clog2(TABLE_DEPTH);
	localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
	localparam int RIDX_W   = 8;
	localparam int ID_CMP_W = (IDX_W > RIDX_W) ? IDX_W : RIDX_W;
	localparam int LIM_W    = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

	// reduction tree: groups of cells OR-ed in the first stage
	localparam int GRP   = 16;
	localparam int GRP_W = $clog2(GRP);
	localparam int NGRP  = (TABLE_DEPTH + GRP - 1) / GRP;

	// result status codes
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_PRESENT   = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_READ_OK   = 3'd3;
	localparam logic [2:0] ST_BAD_INDEX = 3'd4;

	// item kinds
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic             cmp_en;
		logic             shift_en;
		logic             rd_mode;
		logic [RIDX_W-1:0] index;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
		logic [CNT_W-1:0] count;
	} skt_ctrl_t;

	// reduced view of the selected cell
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] pos;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} skt_red_t;

endpackage

>>> sv/skt_cell.sv
// One slot of the sorted row: holds a key and payload, compares and shifts.
// Depends on skt_pkg.
module skt_cell
	import skt_pkg::*;
(
	input  logic             clk,
	input  skt_ctrl_t        ctrl,
	input  logic [IDX_W-1:0] cell_id,
	input  logic             left_lt,
	input  logic [KEY_W-1:0] left_key,
	input  logic [PAY_W-1:0] left_payload,
	output logic             lt,
	output logic [KEY_W-1:0] key,
	output logic [PAY_W-1:0] payload,
	output logic             sel,
	output logic             eq
);

	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;
	logic             sel_q, eq_q, ge_q;
	logic             in_range, ins_here, rd_here;

	assign in_range = CNT_W'(cell_id) < ctrl.count;
	assign lt       = in_range && (key_q < ctrl.key);
	assign ins_here = !lt && left_lt;
	assign rd_here  = ID_CMP_W'(cell_id) == ID_CMP_W'(ctrl.index);

	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			sel_q <= ctrl.rd_mode ? rd_here : ins_here;
			eq_q  <= in_range && (key_q == ctrl.key);
			ge_q  <= !lt;
		end
	end

	// insert: new entry lands at the insert slot, everything above moves up one
	always_ff @(posedge clk) begin
		if (ctrl.shift_en) begin
			if (sel_q) begin
				key_q <= ctrl.key;
				pay_q <= ctrl.payload;
			end else if (ge_q) begin
				key_q <= left_key;
				pay_q <= left_payload;
			end
		end
	end

	assign key     = key_q;
	assign payload = pay_q;
	assign sel     = sel_q;
	assign eq      = eq_q;

endmodule

>>> sv/skt_reduce.sv
// Two-stage registered OR tree that encodes the selected cell and picks its data.
// Depends on skt_pkg.
module skt_reduce
	import skt_pkg::*;
(
	input  logic             clk,
	input  logic             en1,
	input  logic             en2,
	input  logic             sel [TABLE_DEPTH],
	input  logic             eq [TABLE_DEPTH],
	input  logic [KEY_W-1:0] keys [TABLE_DEPTH],
	input  logic [PAY_W-1:0] pays [TABLE_DEPTH],
	output skt_red_t         red
);

	logic             g_any [NGRP];
	logic             g_hit [NGRP];
	logic [GRP_W-1:0] g_lo [NGRP];
	logic [KEY_W-1:0] g_key [NGRP];
	logic [PAY_W-1:0] g_pay [NGRP];

	logic             g_any_s1 [NGRP];
	logic             g_hit_s1 [NGRP];
	logic [GRP_W-1:0] g_lo_s1 [NGRP];
	logic [KEY_W-1:0] g_key_s1 [NGRP];
	logic [PAY_W-1:0] g_pay_s1 [NGRP];

	skt_red_t red_c, red_s2;

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			g_any[g] = 1'b0;
			g_hit[g] = 1'b0;
			g_lo[g]  = '0;
			g_key[g] = '0;
			g_pay[g] = '0;
			for (int j = 0; j < GRP; j++) begin
				if (g * GRP + j < TABLE_DEPTH) begin
					if (sel[g * GRP + j]) begin
						g_any[g] = 1'b1;
						g_hit[g] = g_hit[g] | eq[g * GRP + j];
						g_lo[g]  = g_lo[g] | GRP_W'(j);
						g_key[g] = g_key[g] | keys[g * GRP + j];
						g_pay[g] = g_pay[g] | pays[g * GRP + j];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int g = 0; g < NGRP; g++) begin
				g_any_s1[g] <= g_any[g];
				g_hit_s1[g] <= g_hit[g];
				g_lo_s1[g]  <= g_lo[g];
				g_key_s1[g] <= g_key[g];
				g_pay_s1[g] <= g_pay[g];
			end
		end
	end

	always_comb begin
		red_c = '0;
		for (int g = 0; g < NGRP; g++) begin
			if (g_any_s1[g]) begin
				red_c.hit     = red_c.hit | g_hit_s1[g];
				red_c.pos     = red_c.pos | IDX_W'(g * GRP + int'(g_lo_s1[g]));
				red_c.key     = red_c.key | g_key_s1[g];
				red_c.payload = red_c.payload | g_pay_s1[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			red_s2 <= red_c;
		end
	end

	assign red = red_s2;

endmodule

>>> sv/sorted_key_table_insert_unit.sv
// Sorted key table top: controller, row of skt_cell slots, skt_reduce encoder.
// An item passes compare, two reduction stages and the shift/write step, then returns
// to idle; a new item is accepted only in idle, and the shift/write step holds while
// the result register waits on m_tready.
// Reset (arst_n low): table empty, no result pending; key and payload slots hold
// stale data, which is never read because every access is bounded by the count.
`include "assert_macros.svh"

module sorted_key_table_insert_unit
	import skt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,  // key[31:0], payload[95:32], index[103:96]
	input  logic [0:0]   s_tuser,  // kind[0]: 0 insert, 1 read
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// position[8:0], entry_count[17:9], key_out[49:18], payload_out[113:50], zero pad
	output logic [119:0] m_tdata,
	output logic [2:0]   m_tuser   // status[2:0]
);

	// controller states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CMP  = 3'd1;  // cells compare, latch insert/read slot
	localparam logic [2:0] ST_RED1 = 3'd2;  // group stage of the reduction
	localparam logic [2:0] ST_RED2 = 3'd3;  // final stage of the reduction
	localparam logic [2:0] ST_FIN  = 3'd4;  // shift/write and load result register

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  count_q;

	// captured item
	logic              kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [PAY_W-1:0]  pay_q;
	logic [RIDX_W-1:0] index_q;

	// result register
	logic              out_valid_q;
	logic [2:0]        out_status_q;
	logic [8:0]        out_pos_q;
	logic [8:0]        out_cnt_q;
	logic [31:0]       out_key_q;
	logic [63:0]       out_pay_q;

	skt_ctrl_t         ctrl;
	skt_red_t          red;

	logic              lt_w [TABLE_DEPTH];
	logic [KEY_W-1:0]  key_w [TABLE_DEPTH];
	logic [PAY_W-1:0]  pay_w [TABLE_DEPTH];
	logic              sel_w [TABLE_DEPTH];
	logic              eq_w [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] sel_vec;

	logic              in_xfer, out_free, fin_go;
	logic              full, rd_ok, do_insert;
	logic [2:0]        fin_status;
	logic [CNT_W-1:0]  fin_count;

	assign in_xfer  = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign fin_go   = (state_q == ST_FIN) && out_free;

	assign full      = (count_q == CNT_W'(TABLE_DEPTH));
	assign rd_ok     = LIM_W'(index_q) < LIM_W'(count_q);
	assign do_insert = (kind_q == KIND_INSERT) && !red.hit && !full;

	// broadcast to the row
	always_comb begin
		ctrl          = '0;
		ctrl.cmp_en   = (state_q == ST_CMP);
		ctrl.shift_en = fin_go && do_insert;
		ctrl.rd_mode  = (kind_q == KIND_READ);
		ctrl.index    = index_q;
		ctrl.key      = key_q;
		ctrl.payload  = pay_q;
		ctrl.count    = count_q;
	end

	// row of slots; on a shift the insert slot takes the new entry and each slot above it takes its lower neighbor's entry
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic             l_lt;
		logic [KEY_W-1:0] l_key;
		logic [PAY_W-1:0] l_pay;

		if (i == 0) begin : g_first
			assign l_lt  = 1'b1;
			assign l_key = '0;
			assign l_pay = '0;
		end else begin : g_rest
			assign l_lt  = lt_w[i-1];
			assign l_key = key_w[i-1];
			assign l_pay = pay_w[i-1];
		end

		skt_cell u_cell (
			.clk          (clk),
			.ctrl         (ctrl),
			.cell_id      (IDX_W'(i)),
			.left_lt      (l_lt),
			.left_key     (l_key),
			.left_payload (l_pay),
			.lt           (lt_w[i]),
			.key          (key_w[i]),
			.payload      (pay_w[i]),
			.sel          (sel_w[i]),
			.eq           (eq_w[i])
		);

		assign sel_vec[i] = sel_w[i];
	end

	skt_reduce u_reduce (
		.clk  (clk),
		.en1  (state_q == ST_RED1),
		.en2  (state_q == ST_RED2),
		.sel  (sel_w),
		.eq   (eq_w),
		.keys (key_w),
		.pays (pay_w),
		.red  (red)
	);

	// outcome of the item once the reduction is in
	always_comb begin
		fin_status = ST_INSERTED;
		fin_count  = count_q;
		if (kind_q == KIND_INSERT) begin
			if (red.hit) begin
				fin_status = ST_PRESENT;
			end else if (full) begin
				fin_status = ST_FULL;
			end else begin
				fin_status = ST_INSERTED;
				fin_count  = count_q + 1'b1;
			end
		end else begin
			fin_status = rd_ok ? ST_READ_OK : ST_BAD_INDEX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP:  state_q <= ST_RED1;
				ST_RED1: state_q <= ST_RED2;
				ST_RED2: state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
						count_q <= fin_count;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item capture; the key is cut to the packed quanta width
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q  <= s_tuser[0];
			key_q   <= KEY_W'(s_tdata[31:0]);
			pay_q   <= s_tdata[95:32];
			index_q <= s_tdata[103:96];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// fields that do not apply to the outcome are zero
	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_status_q <= fin_status;
			out_cnt_q    <= 9'(fin_count);
			out_pos_q    <= '0;
			out_key_q    <= '0;
			out_pay_q    <= '0;
			if (fin_status == ST_PRESENT || fin_status == ST_INSERTED) begin
				out_pos_q <= 9'(red.pos);
			end
			if (fin_status == ST_READ_OK) begin
				out_key_q <= 32'(red.key);
				out_pay_q <= red.payload;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {6'd0, out_pay_q, out_key_q, out_cnt_q, out_pos_q};

	`SKT_ASSERT(a_count_bound, count_q <= CNT_W'(TABLE_DEPTH), "entry count above table depth")
	`SKT_ASSERT_IMP(a_count_step, count_q != $past(count_q),
		(count_q == $past(count_q) + 1'b1) && ($past(state_q) == ST_FIN),
		"entry count moved other than by one insert")
	`SKT_ASSERT_NXT(a_accept_cmp, in_xfer, state_q == ST_CMP, "accepted item did not start compare")
	`SKT_ASSERT_IMP(a_one_slot, state_q == ST_RED1, $onehot0(sel_vec), "more than one slot selected")

endmodule
